// File: rtl/task_time_load_profiler_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef TASK_TIME_LOAD_PROFILER_UNIT_MACROS_SVH
`define TASK_TIME_LOAD_PROFILER_UNIT_MACROS_SVH

// Clocked assertion with a reset that masks it.
`define TTLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but checked during reset too.
`define TTLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ttlp_pkg.sv
`timescale 1ns / 1ps
package ttlp_pkg;

  localparam int NUM_SLOTS = 7;
  localparam int SLOT_W    = 3;
  localparam int STAMP_W   = 32;
  localparam int PCT_W     = 7;

  localparam logic [SLOT_W-1:0] SLOT_IDLE1 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_ETH   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_GUI   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_SENS  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_IDLE2 = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_MOTOR = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_MINT  = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_NONE  = 3'd7;

  localparam logic [1:0] ACT_ENTRY = 2'd0;
  localparam logic [1:0] ACT_EXIT  = 2'd1;
  localparam logic [1:0] ACT_PEND  = 2'd2;

  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;
  localparam logic [STAMP_W-1:0] PERIOD_RESET = 32'd12000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXIT,
    ST_GATHER,
    ST_SUM,
    ST_SHARE_GO,
    ST_SHARE_WAIT,
    ST_IDLE_PCT,
    ST_OUT
  } state_t;

endpackage

// File: rtl/ttlp_share_div.sv
`timescale 1ns / 1ps
module ttlp_share_div
  import ttlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [STAMP_W-1:0] part,
  input  logic [STAMP_W-1:0] total,
  output logic               done,
  output logic [PCT_W-1:0]   pct
);

  // part*100 is divided by total one quotient bit a cycle; a part above total
  // means a wrapped sum, and any part not below total saturates at full scale.
  logic               busy;
  logic [2:0]         bit_idx;
  logic [38:0]        rem;
  logic [PCT_W-1:0]   quo;
  logic               sat;
  logic [39:0]        trial;
  logic [PCT_W-1:0]   quo_next;
  logic [38:0]        rem_next;

  always_comb begin
    trial    = {1'b0, rem} - ({8'd0, total} << bit_idx);
    quo_next = quo;
    rem_next = rem;
    if (!trial[39]) begin
      rem_next          = trial[38:0];
      quo_next[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        rem     <= {7'd0, part} * 39'd100;
        sat     <= (part >= total);
        quo     <= '0;
        bit_idx <= 3'd6;
      end else if (busy) begin
        rem     <= rem_next;
        quo     <= quo_next;
        bit_idx <= bit_idx - 3'd1;
        if (bit_idx == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          pct  <= sat ? FULL_PCT : quo_next;
        end
      end
    end
  end

endmodule

// File: rtl/task_time_load_profiler_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------------
// input     | in_valid / in_stall     | action, task_slot, timestamp
// output    | out_valid / out_stall   | ethernet_pct .. idle_pct, idle1/2_changed
// config    | cfg_valid / cfg_ready   | period_count
//
// A task entry is taken without a stall; a task exit stalls the input for the
// read of the stamp and total memories and the write back of the total. A period
// end stalls the input to sweep and add the totals, run four shares through the
// bit-serial divider, form idle and load the output beat; a zero sum skips shares and idle.
// Reset is synchronous; it empties both memories through their valid bits.
// A stalled result holds the output register; a later period end waits to load.
module task_time_load_profiler_unit
  import ttlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [SLOT_W-1:0]  task_slot,
  input  logic [STAMP_W-1:0] timestamp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PCT_W-1:0]   ethernet_pct,
  output logic [PCT_W-1:0]   gui_pct,
  output logic [PCT_W-1:0]   sensors_pct,
  output logic [PCT_W-1:0]   motor_pct,
  output logic [PCT_W-1:0]   idle_pct,
  output logic               idle1_changed,
  output logic               idle2_changed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STAMP_W-1:0] period_count
);

  state_t state, state_next;

  // Start stamps and slot totals live in two small synchronous memories.
  // A valid bit per entry makes an unwritten entry read as zero, so the
  // period end clears both memories by clearing only their valid bits.
  logic [STAMP_W-1:0] st_mem  [NUM_SLOTS];
  logic [STAMP_W-1:0] tot_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] st_valid, tot_valid;
  logic [STAMP_W-1:0] st_q, tot_q;
  logic st_qv, tot_qv;
  logic [STAMP_W-1:0] st_rd, tot_rd;

  logic               st_we, tot_we, clear_all;
  logic [SLOT_W-1:0]  tot_raddr;
  logic [STAMP_W-1:0] tot_wdata;

  logic [STAMP_W-1:0] period_reg;
  logic [SLOT_W-1:0]  ex_slot;
  logic [STAMP_W-1:0] ex_stamp;
  logic [STAMP_W-1:0] delta;

  logic [3:0]         cnt;
  logic [STAMP_W-1:0] gat [NUM_SLOTS];
  logic [STAMP_W-1:0] motor_sum, all_sum;
  logic [STAMP_W-1:0] sum_reg, motor_reg;
  logic [STAMP_W-1:0] prev_idle1, prev_idle2;
  logic               flag1, flag2;
  logic [1:0]         share_idx;
  logic [PCT_W-1:0]   held [5];
  logic [8:0]         others;

  logic               div_start, div_done;
  logic [STAMP_W-1:0] div_part;
  logic [PCT_W-1:0]   div_pct;

  logic in_take;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign st_rd  = st_qv  ? st_q  : '0;
  assign tot_rd = tot_qv ? tot_q : '0;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (action == ACT_EXIT && task_slot != SLOT_NONE) begin
            state_next = ST_EXIT;
          end else if (action == ACT_PEND) begin
            state_next = ST_GATHER;
          end
        end
      end
      ST_EXIT:       state_next = ST_IDLE;
      ST_GATHER:     if (cnt == 4'd7) state_next = ST_SUM;
      ST_SUM:        state_next = (all_sum == '0) ? ST_OUT : ST_SHARE_GO;
      ST_SHARE_GO:   state_next = ST_SHARE_WAIT;
      ST_SHARE_WAIT: begin
        if (div_done) begin
          state_next = (share_idx == 2'd3) ? ST_IDLE_PCT : ST_SHARE_GO;
        end
      end
      ST_IDLE_PCT:   state_next = ST_OUT;
      ST_OUT:        if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    st_we     = 1'b0;
    tot_we    = 1'b0;
    clear_all = 1'b0;
    div_start = 1'b0;
    tot_raddr = task_slot;
    case (state)
      ST_IDLE: begin
        st_we = in_take && action == ACT_ENTRY && task_slot != SLOT_NONE;
      end
      ST_EXIT:     tot_we    = (st_rd != '0);
      ST_GATHER:   tot_raddr = (cnt == 4'd7) ? SLOT_IDLE1 : cnt[SLOT_W-1:0];
      ST_SUM:      clear_all = 1'b1;
      ST_SHARE_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  // Time spent in the slot; the motor interrupt slot adds one period when
  // the timer wrapped between its entry and exit.
  always_comb begin
    delta = ex_stamp - st_rd;
    if (ex_slot == SLOT_MINT && st_rd > ex_stamp) begin
      delta = period_reg + ex_stamp - st_rd;
    end
    tot_wdata = tot_rd + delta;
  end

  assign motor_sum = gat[SLOT_MOTOR] + gat[SLOT_MINT];
  assign all_sum   = gat[SLOT_IDLE1] + gat[SLOT_ETH] + gat[SLOT_GUI]
                   + gat[SLOT_SENS] + motor_sum;
  assign others    = {2'd0, held[0]} + {2'd0, held[1]} + {2'd0, held[2]}
                   + {2'd0, held[3]};

  always_comb begin
    case (share_idx)
      2'd0:    div_part = gat[SLOT_ETH];
      2'd1:    div_part = gat[SLOT_GUI];
      2'd2:    div_part = gat[SLOT_SENS];
      default: div_part = motor_reg;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[task_slot] <= timestamp;
    end
    if (tot_we) begin
      tot_mem[ex_slot] <= tot_wdata;
    end
    st_q  <= st_mem[task_slot];
    tot_q <= tot_mem[tot_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= '0;
      tot_valid <= '0;
      st_qv     <= 1'b0;
      tot_qv    <= 1'b0;
    end else begin
      st_qv  <= st_valid[task_slot];
      tot_qv <= tot_valid[tot_raddr];
      if (clear_all) begin
        st_valid  <= '0;
        tot_valid <= '0;
      end else begin
        if (st_we)  st_valid[task_slot] <= 1'b1;
        if (tot_we) tot_valid[ex_slot]  <= 1'b1;
      end
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      period_reg <= PERIOD_RESET;
      prev_idle1 <= '0;
      prev_idle2 <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 5; i++) held[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        period_reg <= period_count;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          ex_slot  <= task_slot;
          ex_stamp <= timestamp;
          cnt      <= '0;
        end
        ST_GATHER: begin
          cnt <= cnt + 4'd1;
          if (cnt != 4'd0) begin
            gat[cnt[SLOT_W-1:0] - 3'd1] <= tot_rd;
          end
        end
        ST_SUM: begin
          sum_reg    <= all_sum;
          motor_reg  <= motor_sum;
          flag1      <= (prev_idle1 != gat[SLOT_IDLE1]);
          flag2      <= (prev_idle2 != gat[SLOT_IDLE2]);
          prev_idle1 <= gat[SLOT_IDLE1];
          prev_idle2 <= gat[SLOT_IDLE2];
          share_idx  <= '0;
        end
        ST_SHARE_WAIT: begin
          if (div_done) begin
            held[share_idx] <= div_pct;
            share_idx       <= share_idx + 2'd1;
          end
        end
        ST_IDLE_PCT: begin
          held[4] <= (others > 9'd100) ? '0 : FULL_PCT - others[PCT_W-1:0];
        end
        ST_OUT: begin
          if (out_free) begin
            ethernet_pct  <= held[0];
            gui_pct       <= held[1];
            sensors_pct   <= held[2];
            motor_pct     <= held[3];
            idle_pct      <= held[4];
            idle1_changed <= flag1;
            idle2_changed <= flag2;
          end
        end
        default: ;
      endcase
    end
  end

  ttlp_share_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .part  (div_part),
    .total (sum_reg),
    .done  (div_done),
    .pct   (div_pct)
  );

endmodule

// File: rtl/ttlp_checker.sv
`timescale 1ns / 1ps
`include "task_time_load_profiler_unit_macros.svh"
module ttlp_checker
  import ttlp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         action,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PCT_W-1:0]   ethernet_pct,
  input logic [PCT_W-1:0]   gui_pct,
  input logic [PCT_W-1:0]   sensors_pct,
  input logic [PCT_W-1:0]   motor_pct,
  input logic [PCT_W-1:0]   idle_pct
);

  logic [9:0] pct_total;
  assign pct_total = {3'd0, ethernet_pct} + {3'd0, gui_pct} + {3'd0, sensors_pct}
                   + {3'd0, motor_pct} + {3'd0, idle_pct};

  `TTLP_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "output beat dropped while stalled")
  `TTLP_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(idle_pct), "stalled idle_pct changed")
  `TTLP_ASSERT(a_no_quick_result, clk, rst, in_valid && !in_stall && action != ACT_PEND |=> !$rose(out_valid), "result right after a non period-end beat")
  `TTLP_ASSERT(a_idle_fills, clk, rst, out_valid && idle_pct != 7'd0 |-> pct_total == 10'd100, "shares with idle do not add to 100")

endmodule

bind task_time_load_profiler_unit ttlp_checker u_ttlp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .action       (action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .ethernet_pct (ethernet_pct),
  .gui_pct      (gui_pct),
  .sensors_pct  (sensors_pct),
  .motor_pct    (motor_pct),
  .idle_pct     (idle_pct)
);

// File: bench/tb_task_time_load_profiler_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the task load profiler. A behavioral predictor
// tracks the start stamps, slot totals and held percentages. Each period end
// that the block takes pushes one expected result beat, and an output monitor
// compares every beat that leaves the block against the oldest expectation.
module tb_task_time_load_profiler_unit;
  import ttlp_pkg::*;

  // The unused action code, which the block must ignore.
  localparam logic [1:0]        ACT_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [PCT_W-1:0] eth;
    logic [PCT_W-1:0] gui;
    logic [PCT_W-1:0] sens;
    logic [PCT_W-1:0] motor;
    logic [PCT_W-1:0] idle;
    logic             idle1_chg;
    logic             idle2_chg;
  } load_report_t;

  typedef struct {
    logic [1:0]         act;
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] stamp;
    bit                 typed;
    load_report_t       want;
  } event_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = '0;
  logic [SLOT_W-1:0]  task_slot = '0;
  logic [STAMP_W-1:0] timestamp = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PCT_W-1:0]   ethernet_pct, gui_pct, sensors_pct, motor_pct, idle_pct;
  logic               idle1_changed, idle2_changed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [STAMP_W-1:0] period_count = '0;

  task_time_load_profiler_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .task_slot(task_slot), .timestamp(timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .ethernet_pct(ethernet_pct), .gui_pct(gui_pct), .sensors_pct(sensors_pct),
    .motor_pct(motor_pct), .idle_pct(idle_pct),
    .idle1_changed(idle1_changed), .idle2_changed(idle2_changed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .period_count(period_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state, a private copy of what the block should hold.
  logic [STAMP_W-1:0] wrap_period;
  logic [STAMP_W-1:0] entry_stamp [NUM_SLOTS];
  logic [STAMP_W-1:0] busy_total [NUM_SLOTS];
  logic [STAMP_W-1:0] last_idle1, last_idle2;
  load_report_t       held_report;

  load_report_t pending_reports[$];
  event_row_t   directed_rows[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b0;
  logic [STAMP_W-1:0] timer_now;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Floored share in percent, saturated at 100 when the sum has wrapped.
  function automatic logic [PCT_W-1:0] pct_of(input logic [STAMP_W-1:0] part,
                                              input logic [STAMP_W-1:0] whole);
    logic [63:0] q;
    q = ({32'd0, part} * 64'd100) / {32'd0, whole};
    return (q > 64'd100) ? FULL_PCT : q[PCT_W-1:0];
  endfunction

  // Applies one accepted event to the predictor; a period end yields a beat.
  function automatic bit profile_event(input logic [1:0] act,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [STAMP_W-1:0] stamp,
                                       output load_report_t beat);
    logic [STAMP_W-1:0] span, sum;
    logic [8:0] others;
    beat = '0;
    if (act == ACT_ENTRY) begin
      if (slot != SLOT_NONE) entry_stamp[slot] = stamp;
      return 1'b0;
    end
    if (act == ACT_EXIT) begin
      if (slot != SLOT_NONE && entry_stamp[slot] != '0) begin
        span = stamp - entry_stamp[slot];
        // Only the interrupt slot knows about the timer period.
        if (slot == SLOT_MINT && entry_stamp[slot] > stamp)
          span = wrap_period + stamp - entry_stamp[slot];
        busy_total[slot] = busy_total[slot] + span;
      end
      return 1'b0;
    end
    if (act != ACT_PEND) return 1'b0;
    busy_total[SLOT_MOTOR] = busy_total[SLOT_MOTOR] + busy_total[SLOT_MINT];
    sum = busy_total[SLOT_IDLE1] + busy_total[SLOT_ETH] + busy_total[SLOT_GUI]
        + busy_total[SLOT_MOTOR] + busy_total[SLOT_SENS];
    beat.idle1_chg = (last_idle1 != busy_total[SLOT_IDLE1]);
    beat.idle2_chg = (last_idle2 != busy_total[SLOT_IDLE2]);
    last_idle1 = busy_total[SLOT_IDLE1];
    last_idle2 = busy_total[SLOT_IDLE2];
    // A zero sum keeps the previous percentages.
    if (sum != '0) begin
      held_report.eth   = pct_of(busy_total[SLOT_ETH], sum);
      held_report.gui   = pct_of(busy_total[SLOT_GUI], sum);
      held_report.sens  = pct_of(busy_total[SLOT_SENS], sum);
      held_report.motor = pct_of(busy_total[SLOT_MOTOR], sum);
      others = 9'(held_report.eth) + 9'(held_report.gui)
             + 9'(held_report.sens) + 9'(held_report.motor);
      held_report.idle = (others > 9'd100) ? '0 : 7'(9'd100 - others);
    end
    beat.eth   = held_report.eth;
    beat.gui   = held_report.gui;
    beat.sens  = held_report.sens;
    beat.motor = held_report.motor;
    beat.idle  = held_report.idle;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      entry_stamp[i] = '0;
      busy_total[i] = '0;
    end
    return 1'b1;
  endfunction

  // Drives one input beat, holds it through any stall, then predicts it.
  task automatic send_event(input logic [1:0] act, input logic [SLOT_W-1:0] slot,
                            input logic [STAMP_W-1:0] stamp, input bit typed,
                            input load_report_t want);
    load_report_t beat;
    while (gaps_on && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    task_slot <= slot;
    timestamp <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (profile_event(act, slot, stamp, beat))
      pending_reports.push_back(typed ? want : beat);
  endtask

  task automatic send_plain(input logic [1:0] act, input logic [SLOT_W-1:0] slot,
                            input logic [STAMP_W-1:0] stamp);
    send_event(act, slot, stamp, 1'b0, '0);
  endtask

  // Waits until every period end has reported, then lets the block settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [STAMP_W-1:0] value);
    cfg_valid    <= 1'b1;
    period_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    wrap_period = value;
  endtask

  task automatic add_row(input logic [1:0] act, input logic [SLOT_W-1:0] slot,
                         input logic [STAMP_W-1:0] stamp, input bit typed,
                         input load_report_t want);
    event_row_t r;
    r.act = act;
    r.slot = slot;
    r.stamp = stamp;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // Random traffic: mostly matched entry and exit pairs on a rising timer,
  // some period ends, and some raw noise across every field bit.
  task automatic random_phase(input int count);
    int taken;
    int pick;
    logic [SLOT_W-1:0] slot;
    logic [STAMP_W-1:0] start;
    logic [1:0] act;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        send_plain(ACT_PEND, 3'($urandom_range(0, 7)), $urandom);
        taken++;
      end else if (pick < 20) begin
        act  = 2'($urandom_range(0, 3));
        slot = 3'($urandom_range(0, 7));
        send_plain(act, slot, $urandom);
        if (act != ACT_UNUSED && (act == ACT_PEND || slot != SLOT_NONE)) taken++;
      end else begin
        slot = 3'($urandom_range(0, 6));
        start = timer_now;
        send_plain(ACT_ENTRY, slot, start);
        timer_now = timer_now + $urandom_range(0, 3000);
        // Some interrupt exits land after the timer has wrapped around.
        if (slot == SLOT_MINT && $urandom_range(0, 3) == 0)
          send_plain(ACT_EXIT, slot, $urandom_range(0, start));
        else
          send_plain(ACT_EXIT, slot, timer_now);
        timer_now = timer_now + $urandom_range(0, 500);
        taken += 2;
      end
    end
  endtask

  // The output side stalls at random while gaps are enabled.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk) begin
    load_report_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_beat = pending_reports.pop_front();
        if (ethernet_pct !== exp_beat.eth)
          report_mismatch($sformatf("ethernet_pct %0d want %0d", ethernet_pct, exp_beat.eth));
        if (gui_pct !== exp_beat.gui)
          report_mismatch($sformatf("gui_pct %0d want %0d", gui_pct, exp_beat.gui));
        if (sensors_pct !== exp_beat.sens)
          report_mismatch($sformatf("sensors_pct %0d want %0d", sensors_pct, exp_beat.sens));
        if (motor_pct !== exp_beat.motor)
          report_mismatch($sformatf("motor_pct %0d want %0d", motor_pct, exp_beat.motor));
        if (idle_pct !== exp_beat.idle)
          report_mismatch($sformatf("idle_pct %0d want %0d", idle_pct, exp_beat.idle));
        if (idle1_changed !== exp_beat.idle1_chg)
          report_mismatch($sformatf("idle1_changed %0b want %0b", idle1_changed,
                                    exp_beat.idle1_chg));
        if (idle2_changed !== exp_beat.idle2_chg)
          report_mismatch($sformatf("idle2_changed %0b want %0b", idle2_changed,
                                    exp_beat.idle2_chg));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL task_time_load_profiler_unit");
      $finish;
    end
  end

  initial begin
    load_report_t zero_beat, eth_full;
    zero_beat = '0;
    eth_full = '0;
    eth_full.eth = FULL_PCT;
    wrap_period = PERIOD_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      entry_stamp[i] = '0;
      busy_total[i] = '0;
    end
    last_idle1 = '0;
    last_idle2 = '0;
    held_report = '0;
    timer_now = $urandom_range(1, 1000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows. Right after reset a period end reports all zeros, and a
    // lone ethernet run owns the whole period.
    add_row(ACT_PEND, SLOT_IDLE1, 32'd0, 1'b1, zero_beat);
    add_row(ACT_ENTRY, SLOT_ETH, 32'd1, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_ETH, 32'd101, 1'b0, '0);
    add_row(ACT_PEND, SLOT_IDLE1, 32'd0, 1'b1, eth_full);
    // Zero sum: the percentages are held while the flags stay live.
    add_row(ACT_PEND, SLOT_NONE, 32'hFFFF_FFFF, 1'b1, eth_full);
    // Ethernet run across the top of the timer, wrapping modulo 2^32.
    add_row(ACT_ENTRY, SLOT_ETH, 32'hFFFF_FFF0, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_ETH, 32'h0000_0010, 1'b0, '0);
    add_row(ACT_ENTRY, SLOT_IDLE1, 32'd100, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_IDLE1, 32'd200, 1'b0, '0);
    // Interrupt exit after a timer wrap adds the configured period.
    add_row(ACT_ENTRY, SLOT_MINT, 32'd11000, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_MINT, 32'd500, 1'b0, '0);
    // An entry stamp of zero makes the exit count nothing.
    add_row(ACT_ENTRY, SLOT_GUI, 32'd0, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_GUI, 32'd50, 1'b0, '0);
    // Out-of-range slot and the unused action are both dropped.
    add_row(ACT_ENTRY, SLOT_NONE, 32'd7, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_NONE, 32'd9, 1'b0, '0);
    add_row(ACT_UNUSED, SLOT_SENS, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ACT_ENTRY, SLOT_IDLE2, 32'd5, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_IDLE2, 32'd9, 1'b0, '0);
    add_row(ACT_ENTRY, SLOT_SENS, 32'd300, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_SENS, 32'd900, 1'b0, '0);
    add_row(ACT_PEND, SLOT_MOTOR, 32'd0, 1'b0, '0);
    // Huge totals make the sum wrap, so shares saturate and idle hits zero.
    add_row(ACT_ENTRY, SLOT_ETH, 32'd1, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_ETH, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ACT_ENTRY, SLOT_MOTOR, 32'd1, 1'b0, '0);
    add_row(ACT_EXIT, SLOT_MOTOR, 32'h10, 1'b0, '0);
    add_row(ACT_PEND, SLOT_IDLE1, 32'd0, 1'b0, '0);

    write_period(32'd12000);
    foreach (directed_rows[i])
      send_event(directed_rows[i].act, directed_rows[i].slot, directed_rows[i].stamp,
                 directed_rows[i].typed, directed_rows[i].want);
    drain_block();

    // First random phase runs with no gaps on either side.
    write_period(32'd1);
    random_phase(300);
    drain_block();
    gaps_on = 1'b1;
    write_period(32'hFFFF_FFFF);
    random_phase(250);
    drain_block();
    write_period($urandom_range(1, 32'h7FFF_FFFF));
    random_phase(250);
    drain_block();
    write_period(PERIOD_RESET);
    random_phase(250);
    drain_block();

    if (fail_count == 0) begin
      $display("PASS task_time_load_profiler_unit");
    end else begin
      $display("FAIL task_time_load_profiler_unit");
    end
    $finish;
  end

endmodule
